// File: design/gtb_pkg.sv
// ----------------------------------------------------------------------------
// gtb_pkg
// Shared types and constants of the Goertzel tone bank: register map, reset
// values, widths of the shared multiply-accumulate unit and its control codes.
// ----------------------------------------------------------------------------
package gtb_pkg;

  // Configuration register map (word index, byte address 4*index).
  localparam int ADDR_W = 5;
  localparam logic [2:0] REG_BLOCK_LENGTH = 3'd0;
  localparam logic [2:0] REG_THRESHOLD    = 3'd1;
  localparam logic [2:0] REG_COEF_01      = 3'd2;
  localparam logic [2:0] REG_COEF_23      = 3'd3;
  localparam logic [2:0] REG_COEF_45      = 3'd4;
  localparam logic [2:0] REG_COEF_67      = 3'd5;

  // Reset values of the registers.
  localparam logic [15:0] BLOCK_LENGTH_RST = 16'd205;
  localparam logic [30:0] THRESHOLD_RST    = 31'd9000000;
  localparam logic [31:0] COEF_01_RST      = 32'd27460020;
  localparam logic [31:0] COEF_23_RST      = 32'd24904080;
  localparam logic [31:0] COEF_45_RST      = 32'd16908586;
  localparam logic [31:0] COEF_67_RST      = 32'd9371850;

  // Shared unit widths: signed operands, product and power accumulator.
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 80;
  // Scaled feedback term (coef * s1) >> 8, wide enough for a 32-bit state.
  localparam int P_W    = 40;

  // Accumulator operations.
  localparam logic [2:0] ACC_HOLD     = 3'd0;
  localparam logic [2:0] ACC_LOAD     = 3'd1;
  localparam logic [2:0] ACC_ADD      = 3'd2;
  localparam logic [2:0] ACC_SUB      = 3'd3;
  localparam logic [2:0] ACC_SUB_SH16 = 3'd4;

  typedef struct packed {
    logic [15:0]      block_length;
    logic [30:0]      power_threshold;
    logic [3:0][31:0] coef;
  } gtb_cfg_t;

  typedef struct packed {
    logic       mul_en;
    logic [2:0] acc_op;
  } gtb_mac_ctrl_t;

endpackage

// File: design/gtb_cfg_regs.sv
// ----------------------------------------------------------------------------
// gtb_cfg_regs
// APB-style configuration registers: block length, detection threshold and
// four words of packed Q8 coefficients. Always ready, zero-wait reads.
// ----------------------------------------------------------------------------
module gtb_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gtb_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output gtb_pkg::gtb_cfg_t           cfg
);
  import gtb_pkg::*;

  logic [2:0] reg_index;
  logic       write_en;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign write_en  = psel & penable & pwrite;

  // Register writes; an unknown index leaves everything unchanged.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.block_length    <= BLOCK_LENGTH_RST;
      cfg.power_threshold <= THRESHOLD_RST;
      cfg.coef[0]         <= COEF_01_RST;
      cfg.coef[1]         <= COEF_23_RST;
      cfg.coef[2]         <= COEF_45_RST;
      cfg.coef[3]         <= COEF_67_RST;
    end else if (write_en) begin
      case (reg_index)
        REG_BLOCK_LENGTH: cfg.block_length    <= pwdata[15:0];
        REG_THRESHOLD:    cfg.power_threshold <= pwdata[30:0];
        REG_COEF_01:      cfg.coef[0]         <= pwdata;
        REG_COEF_23:      cfg.coef[1]         <= pwdata;
        REG_COEF_45:      cfg.coef[2]         <= pwdata;
        REG_COEF_67:      cfg.coef[3]         <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // Read mux.
  always_comb begin
    case (reg_index)
      REG_BLOCK_LENGTH: prdata = 32'(cfg.block_length);
      REG_THRESHOLD:    prdata = 32'(cfg.power_threshold);
      REG_COEF_01:      prdata = cfg.coef[0];
      REG_COEF_23:      prdata = cfg.coef[1];
      REG_COEF_45:      prdata = cfg.coef[2];
      REG_COEF_67:      prdata = cfg.coef[3];
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// File: design/gtb_mac_unit.sv
// ----------------------------------------------------------------------------
// gtb_mac_unit
// Shared signed multiplier with a registered product, followed by a wide
// accumulator that builds the bin power from successive products.
// ----------------------------------------------------------------------------
module gtb_mac_unit (
  input  logic                              clk,
  input  gtb_pkg::gtb_mac_ctrl_t            ctrl,
  input  logic signed [gtb_pkg::MUL_W-1:0]  op_a,
  input  logic signed [gtb_pkg::MUL_W-1:0]  op_b,
  output logic signed [gtb_pkg::PROD_W-1:0] prod,
  output logic signed [gtb_pkg::ACC_W-1:0]  acc
);
  import gtb_pkg::*;

  logic signed [ACC_W-1:0] prod_ext;

  assign prod_ext = ACC_W'(prod);

  // Multiplier stage: the product is registered before any use.
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= op_a * op_b;
    end
  end

  // Accumulator stage.
  always_ff @(posedge clk) begin
    case (ctrl.acc_op)
      ACC_LOAD:     acc <= prod_ext;
      ACC_ADD:      acc <= acc + prod_ext;
      ACC_SUB:      acc <= acc - prod_ext;
      ACC_SUB_SH16: acc <= acc - (prod_ext <<< 16);
      default:      acc <= acc;
    endcase
  end

endmodule

// File: design/goertzel_tone_bank_top.sv
// ----------------------------------------------------------------------------
// goertzel_tone_bank_top
// Bank of Goertzel resonators over unsigned 8-bit samples.
//
// Samples enter on sample/sample_valid/sample_ready. Each sample updates every
// bin in turn through one shared multiplier, with a multiply step and a
// write-back step per bin, before sample_ready returns.
// After block_length samples (at least one) the block computes one power per
// bin on the same multiplier and hands the results out in bin order on
// bin_index/power/detected/last_bin with result_valid/result_ready.
// last_bin marks the highest bin. The sample count is cleared as the power
// pass starts, and each bin's resonator state as its power goes out.
// The result channel has its own output register, so a waiting result never
// blocks the next sample once the last bin has been loaded; a stalled
// receiver only holds up the power pass at the next bin.
// Registers must be written over the APB-style port while the block is idle;
// the block itself does not enforce this. Reset (rst, synchronous) clears the
// resonators, the count and the output valid, and loads the register defaults.
// ----------------------------------------------------------------------------
module goertzel_tone_bank_top #(
  parameter int NUM_BINS    = 8,
  parameter int STATE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  // APB-style configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gtb_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Sample channel
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  logic [7:0]                  sample,
  // Result channel
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [2:0]                  bin_index,
  output logic signed [63:0]          power,
  output logic                        detected,
  output logic                        last_bin
);
  import gtb_pkg::*;

  localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

  // Sequencer states.
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_UPD_MUL  = 4'd1;
  localparam logic [3:0] ST_UPD_WB   = 4'd2;
  localparam logic [3:0] ST_PWR_COEF = 4'd3;
  localparam logic [3:0] ST_PWR_SQ1  = 4'd4;
  localparam logic [3:0] ST_PWR_SQ2  = 4'd5;
  localparam logic [3:0] ST_PWR_LO   = 4'd6;
  localparam logic [3:0] ST_PWR_HI   = 4'd7;
  localparam logic [3:0] ST_PWR_ACC  = 4'd8;
  localparam logic [3:0] ST_PWR_OUT  = 4'd9;

  gtb_cfg_t      cfg;
  gtb_mac_ctrl_t mac_ctrl;

  logic [3:0]       state;
  logic [BIN_W-1:0] bin;
  logic [15:0]      sample_count;
  logic [7:0]       x_reg;
  logic signed [P_W-1:0] p_reg;

  logic [STATE_WIDTH-1:0] delay_one [NUM_BINS];
  logic [STATE_WIDTH-1:0] delay_two [NUM_BINS];

  logic signed [MUL_W-1:0]  op_a;
  logic signed [MUL_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic [STATE_WIDTH-1:0] s1;
  logic [STATE_WIDTH-1:0] s2;
  logic [STATE_WIDTH-1:0] s_new;
  logic signed [15:0]     coef;
  logic [3:0]             bin_ext;
  logic [15:0]            count_next;
  logic [63:0]            power_sat;
  logic                   over_threshold;
  logic                   out_load;

  gtb_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gtb_mac_unit u_mac_unit (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod),
    .acc  (acc)
  );

  // Coefficient of the current bin; bins past the register file use zero.
  function automatic logic signed [15:0] coef_of(input logic [3:0] b,
                                                 input logic [3:0][31:0] regs);
    logic [31:0] word;
    begin
      word = regs[b[2:1]];
      if (b[3]) begin
        coef_of = 16'sd0;
      end else if (b[0]) begin
        coef_of = $signed(word[31:16]);
      end else begin
        coef_of = $signed(word[15:0]);
      end
    end
  endfunction

  assign bin_ext = 4'(bin);
  assign coef    = coef_of(bin_ext, cfg.coef);
  assign s1      = delay_one[bin];
  assign s2      = delay_two[bin];

  // Resonator update: x + ((coef*s1) >> 8) - s2, wrapped to the state width.
  assign s_new = prod[STATE_WIDTH+7:8] + STATE_WIDTH'(x_reg) - s2;

  assign count_next   = sample_count + 16'd1;
  assign sample_ready = (state == ST_IDLE);
  assign out_load     = (state == ST_PWR_OUT) && (!result_valid || result_ready);

  // Saturate the exact power to 64 bits and compare with the threshold.
  always_comb begin
    if ((&acc[ACC_W-1:63]) || !(|acc[ACC_W-1:63])) begin
      power_sat = acc[63:0];
    end else if (acc[ACC_W-1]) begin
      power_sat = {1'b1, 63'd0};
    end else begin
      power_sat = {1'b0, {63{1'b1}}};
    end
    over_threshold = !power_sat[63] &&
                     ((|power_sat[62:31]) || (power_sat[30:0] > cfg.power_threshold));
  end

  // Operand selection and accumulator control for each sequencer step.
  always_comb begin
    op_a            = MUL_W'(coef);
    op_b            = MUL_W'($signed(s1));
    mac_ctrl.mul_en = 1'b0;
    mac_ctrl.acc_op = ACC_HOLD;
    case (state)
      ST_UPD_MUL, ST_PWR_COEF: begin
        mac_ctrl.mul_en = 1'b1;
      end
      ST_PWR_SQ1: begin
        op_a            = MUL_W'($signed(s1));
        mac_ctrl.mul_en = 1'b1;
      end
      ST_PWR_SQ2: begin
        op_a            = MUL_W'($signed(s2));
        op_b            = MUL_W'($signed(s2));
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = ACC_LOAD;
      end
      ST_PWR_LO: begin
        op_a            = MUL_W'(p_reg[15:0]);
        op_b            = MUL_W'($signed(s2));
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = ACC_ADD;
      end
      ST_PWR_HI: begin
        op_a            = MUL_W'($signed(p_reg[P_W-1:16]));
        op_b            = MUL_W'($signed(s2));
        mac_ctrl.mul_en = 1'b1;
        mac_ctrl.acc_op = ACC_SUB;
      end
      ST_PWR_ACC: begin
        mac_ctrl.acc_op = ACC_SUB_SH16;
      end
      default: begin
      end
    endcase
  end

  // Sequencer: per-bin update pass, then the power pass at block end.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      bin          <= '0;
      sample_count <= 16'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (sample_valid) begin
            bin   <= '0;
            state <= ST_UPD_MUL;
          end
        end
        ST_UPD_MUL: begin
          state <= ST_UPD_WB;
        end
        ST_UPD_WB: begin
          if (bin == LAST_BIN) begin
            bin <= '0;
            if (count_next >= cfg.block_length) begin
              sample_count <= 16'd0;
              state        <= ST_PWR_COEF;
            end else begin
              sample_count <= count_next;
              state        <= ST_IDLE;
            end
          end else begin
            bin   <= bin + BIN_W'(1);
            state <= ST_UPD_MUL;
          end
        end
        ST_PWR_COEF: state <= ST_PWR_SQ1;
        ST_PWR_SQ1:  state <= ST_PWR_SQ2;
        ST_PWR_SQ2:  state <= ST_PWR_LO;
        ST_PWR_LO:   state <= ST_PWR_HI;
        ST_PWR_HI:   state <= ST_PWR_ACC;
        ST_PWR_ACC:  state <= ST_PWR_OUT;
        ST_PWR_OUT: begin
          if (out_load) begin
            if (bin == LAST_BIN) begin
              bin   <= '0;
              state <= ST_IDLE;
            end else begin
              bin   <= bin + BIN_W'(1);
              state <= ST_PWR_COEF;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Captured sample and scaled feedback term.
  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      x_reg <= sample;
    end
    if (state == ST_PWR_SQ1) begin
      p_reg <= prod[P_W+7:8];
    end
  end

  // Resonator state: written back per bin, cleared as each power goes out.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        delay_one[i] <= '0;
        delay_two[i] <= '0;
      end
    end else if (state == ST_UPD_WB) begin
      delay_one[bin] <= s_new;
      delay_two[bin] <= s1;
    end else if (out_load) begin
      delay_one[bin] <= '0;
      delay_two[bin] <= '0;
    end
  end

  // Result output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      bin_index <= bin_ext[2:0];
      power     <= power_sat;
      detected  <= over_threshold;
      last_bin  <= (bin == LAST_BIN);
    end
  end

endmodule

// File: verif/tb_goertzel_tone_bank_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_goertzel_tone_bank_top
// Self-checking bench for the Goertzel tone bank. A directed table covers
// short blocks with hand-computed powers, coefficient extremes that wrap the
// resonator state and saturate the power, an unused register address and a
// block length lowered in the middle of a block. Random phases follow, each
// with a fresh mix of registers, sender gaps and receiver stalls. Every bin
// result is compared with an in-bench resonator model or hand-computed power.
// ----------------------------------------------------------------------------
module tb_goertzel_tone_bank_top;
  import gtb_pkg::*;

  localparam int BANK_BINS     = 8;
  localparam int SETTLE_CYCLES = 64;
  localparam int DRAIN_CYCLES  = 200;
  localparam int RANDOM_ITEMS  = 400;
  localparam int MAX_REPORTS   = 10;
  // Address inside the decoded range that holds no register.
  localparam logic [2:0] REG_SPARE = 3'd6;

  typedef enum logic {ROW_CFG, ROW_SAMPLE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [2:0]         idx;
    logic [31:0]        val;
    bit                 typed;
    logic signed [63:0] pw;
    bit                 det;
  } stim_row_t;

  typedef struct {
    logic [2:0]         bin;
    logic signed [63:0] power;
    logic               det;
    logic               last;
  } bin_result_t;

  // DUT signals
  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               sample_valid;
  logic               sample_ready;
  logic [7:0]         sample;
  logic               result_valid;
  logic               result_ready;
  logic [2:0]         bin_index;
  logic signed [63:0] power;
  logic               detected;
  logic               last_bin;

  // Register copy and resonator state of the tone model
  logic [15:0]        cfg_len;
  logic [30:0]        cfg_thr;
  logic [31:0]        cfg_coef [4];
  logic signed [31:0] res_d1 [BANK_BINS];
  logic signed [31:0] res_d2 [BANK_BINS];
  logic [15:0]        smp_count;
  bin_result_t        blk_out [BANK_BINS];
  bin_result_t        pending_bins [$];
  bin_result_t        want_bin;
  stim_row_t          dir_rows [$];

  // Traffic shaping and bookkeeping
  int burst_left = 0;
  int gap_max    = 0;
  int stall_pct  = 0;
  int stall_hold = 0;
  int errors     = 0;
  int n_samples  = 0;
  int n_blocks   = 0;
  int n_results  = 0;
  int n_cfg      = 0;

  goertzel_tone_bank_top u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .bin_index    (bin_index),
    .power        (power),
    .detected     (detected),
    .last_bin     (last_bin)
  );

  // Clock generation.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void note_error(string msg);
    errors++;
    if (errors <= MAX_REPORTS) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
  endfunction

  function automatic void add_cfg(logic [2:0] idx, logic [31:0] val);
    stim_row_t r;
    r.kind  = ROW_CFG;
    r.idx   = idx;
    r.val   = val;
    r.typed = 1'b0;
    r.pw    = '0;
    r.det   = 1'b0;
    dir_rows.push_back(r);
  endfunction

  function automatic void add_smp(logic [7:0] x, bit typed, logic signed [63:0] pw, bit det);
    stim_row_t r;
    r.kind  = ROW_SAMPLE;
    r.idx   = '0;
    r.val   = {24'd0, x};
    r.typed = typed;
    r.pw    = pw;
    r.det   = det;
    dir_rows.push_back(r);
  endfunction

  // Signed Q8 coefficient of one bin, taken from its packed register half.
  function automatic logic signed [15:0] bin_coef(int b);
    return cfg_coef[b / 2][(b % 2) * 16 +: 16];
  endfunction

  // Random coefficient half: tone-like values, extremes, zero or anything.
  function automatic logic [15:0] rand_coef();
    case ($urandom_range(5))
      0: return 16'($urandom_range(0, 512));
      1: return 16'(0 - $urandom_range(0, 512));
      2: return 16'h7FFF;
      3: return 16'h8000;
      4: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  // Advance all resonators by one sample; on a completed block fill blk_out
  // with the saturated powers and clear the state.
  task automatic tone_step(input logic [7:0] x, output bit done);
    logic signed [15:0] c;
    logic signed [63:0] prod;
    logic signed [63:0] s;
    logic signed [79:0] a1;
    logic signed [79:0] a2;
    logic signed [79:0] fb;
    logic signed [79:0] acc;
    logic signed [63:0] pw;
    for (int i = 0; i < BANK_BINS; i++) begin
      c = bin_coef(i);
      prod = c * res_d1[i];
      s = $signed({56'd0, x}) + (prod >>> 8) - res_d2[i];
      res_d2[i] = res_d1[i];
      res_d1[i] = s[31:0];
    end
    smp_count = smp_count + 16'd1;
    done = (smp_count >= cfg_len);
    if (done) begin
      for (int i = 0; i < BANK_BINS; i++) begin
        c = bin_coef(i);
        prod = c * res_d1[i];
        fb = prod >>> 8;
        a1 = res_d1[i];
        a2 = res_d2[i];
        acc = a1 * a1 + a2 * a2 - fb * a2;
        // Saturate when the top bits are not a pure sign extension.
        if (acc[79:63] == {17{acc[79]}}) begin
          pw = acc[63:0];
        end else begin
          pw = acc[79] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        blk_out[i].bin   = 3'(i);
        blk_out[i].power = pw;
        blk_out[i].det   = !pw[63] && (pw > $signed({33'd0, cfg_thr}));
        blk_out[i].last  = (i == BANK_BINS - 1);
        res_d1[i] = '0;
        res_d2[i] = '0;
      end
      smp_count = '0;
    end
  endtask

  // Present one sample, honoring the burst/gap pattern, and queue the bin
  // results it completes once the transaction is accepted.
  task automatic send_sample(input logic [7:0] x, input bit typed,
                             input logic signed [63:0] tpw, input bit tdet);
    bit done;
    @(negedge clk);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        sample_valid = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    sample_valid = 1'b1;
    sample = x;
    do @(posedge clk); while (!sample_ready);
    tone_step(x, done);
    n_samples++;
    if (done) begin
      n_blocks++;
      for (int i = 0; i < BANK_BINS; i++) begin
        if (typed) begin
          blk_out[i].power = tpw;
          blk_out[i].det   = tdet;
        end
        pending_bins.push_back(blk_out[i]);
      end
    end
  endtask

  // Stop sending, wait for every queued result, then let the block settle.
  task automatic wait_idle();
    @(negedge clk);
    sample_valid = 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write followed by a read-back of the same address.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    logic [31:0] want;
    logic [31:0] got;
    bit known;
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    known = 1'b1;
    want  = '0;
    case (idx)
      REG_BLOCK_LENGTH: begin
        cfg_len = val[15:0];
        want = {16'd0, cfg_len};
      end
      REG_THRESHOLD: begin
        cfg_thr = val[30:0];
        want = {1'b0, cfg_thr};
      end
      REG_COEF_01, REG_COEF_23, REG_COEF_45, REG_COEF_67: begin
        cfg_coef[2'(idx - REG_COEF_01)] = val;
        want = val;
      end
      default: known = 1'b0;
    endcase
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    n_cfg++;
    if (known && got !== want) begin
      note_error($sformatf("register %0d read back %h, expected %h", idx, got, want));
    end
  endtask

  // Receiver: random stalls at a per-phase rate, with occasional long holds.
  always @(negedge clk) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
      result_ready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      result_ready <= 1'b0;
      if ($urandom_range(31) == 0) begin
        stall_hold <= $urandom_range(30);
      end
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Result checker: each accepted transaction against the oldest expectation.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      n_results++;
      if (pending_bins.size() == 0) begin
        note_error($sformatf("unexpected result: bin %0d power %0d det %0b last %0b",
                             bin_index, power, detected, last_bin));
      end else begin
        want_bin = pending_bins.pop_front();
        if (bin_index !== want_bin.bin || power !== want_bin.power ||
            detected !== want_bin.det || last_bin !== want_bin.last) begin
          note_error($sformatf({"expected bin %0d power %0d det %0b last %0b, ",
                                "got bin %0d power %0d det %0b last %0b"},
                               want_bin.bin, want_bin.power, want_bin.det, want_bin.last,
                               bin_index, power, detected, last_bin));
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #10ms;
    $display("Timeout with %0d bin results outstanding", pending_bins.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Main sequence.
  initial begin
    int k;
    int n;
    int rand_items;
    logic [31:0] v;
    logic [15:0] len;
    logic [7:0] x;

    rst          = 1'b1;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    sample_valid = 1'b0;
    sample       = '0;
    cfg_len      = BLOCK_LENGTH_RST;
    cfg_thr      = THRESHOLD_RST;
    cfg_coef[0]  = COEF_01_RST;
    cfg_coef[1]  = COEF_23_RST;
    cfg_coef[2]  = COEF_45_RST;
    cfg_coef[3]  = COEF_67_RST;
    for (int i = 0; i < BANK_BINS; i++) begin
      res_d1[i] = '0;
      res_d2[i] = '0;
    end
    smp_count = '0;

    // Directed table. With one sample per block from cleared state the power
    // of every bin is just the sample squared.
    add_cfg(REG_BLOCK_LENGTH, 32'd1);
    add_cfg(REG_THRESHOLD, 32'd65024);
    add_smp(8'd0, 1'b1, 64'sd0, 1'b0);
    add_smp(8'd255, 1'b1, 64'sd65025, 1'b1);
    add_cfg(REG_THRESHOLD, 32'd65025);
    add_smp(8'd255, 1'b1, 64'sd65025, 1'b0);
    // Length zero, upper write bits must be dropped.
    add_cfg(REG_BLOCK_LENGTH, 32'hABCD_0000);
    add_smp(8'd128, 1'b1, 64'sd16384, 1'b0);
    // Largest threshold and coefficient extremes, then a block long enough
    // to wrap the state and saturate the power.
    add_cfg(REG_THRESHOLD, 32'hFFFF_FFFF);
    add_cfg(REG_COEF_01, 32'h7FFF_8000);
    add_cfg(REG_COEF_23, 32'h8000_7FFF);
    add_cfg(REG_COEF_45, 32'h0000_FFFF);
    add_cfg(REG_COEF_67, 32'h01FF_FE01);
    add_cfg(REG_BLOCK_LENGTH, 32'd6);
    for (k = 0; k < 6; k++) add_smp(8'd255, 1'b0, 64'sd0, 1'b0);
    // A write to the unused address must change nothing.
    add_cfg(REG_SPARE, 32'h5A5A_5A5A);
    add_cfg(REG_THRESHOLD, 32'd0);
    add_cfg(REG_BLOCK_LENGTH, 32'd2);
    add_smp(8'd0, 1'b0, 64'sd0, 1'b0);
    add_smp(8'd1, 1'b0, 64'sd0, 1'b0);
    // Longest block, then lowered while samples are already counted.
    add_cfg(REG_BLOCK_LENGTH, 32'h0000_FFFF);
    add_smp(8'd17, 1'b0, 64'sd0, 1'b0);
    add_smp(8'd200, 1'b0, 64'sd0, 1'b0);
    add_smp(8'd99, 1'b0, 64'sd0, 1'b0);
    add_cfg(REG_BLOCK_LENGTH, 32'd2);
    add_smp(8'd3, 1'b0, 64'sd0, 1'b0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    gap_max   = 2;
    stall_pct = 30;
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        wait_idle();
        cfg_write(dir_rows[r].idx, dir_rows[r].val);
      end else begin
        send_sample(dir_rows[r].val[7:0], dir_rows[r].typed, dir_rows[r].pw,
                    dir_rows[r].det);
      end
    end

    // Random phases: new settings once the bank has drained.
    rand_items = 0;
    while (rand_items < RANDOM_ITEMS) begin
      wait_idle();
      if ($urandom_range(3) != 0) begin
        case ($urandom_range(9))
          0:             len = 16'd0;
          1:             len = 16'd1;
          2, 3, 4, 5:    len = 16'($urandom_range(2, 6));
          6, 7:          len = 16'($urandom_range(7, 24));
          8:             len = 16'hFFFF;
          default:       len = 16'($urandom_range(25, 40));
        endcase
        v = $urandom();
        v[15:0] = len;
        cfg_write(REG_BLOCK_LENGTH, v);
      end
      if ($urandom_range(1) == 0) begin
        case ($urandom_range(3))
          0:       v = 32'd0;
          1:       v = 32'hFFFF_FFFF;
          2:       v = $urandom_range(0, 32'h00FF_FFFF);
          default: v = $urandom();
        endcase
        cfg_write(REG_THRESHOLD, v);
      end
      for (k = 0; k < 4; k++) begin
        if ($urandom_range(2) == 0) cfg_write(3'(REG_COEF_01 + k), {rand_coef(), rand_coef()});
      end
      if ($urandom_range(9) == 0) cfg_write(REG_SPARE, $urandom());

      case ($urandom_range(4))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 25;
        3:       stall_pct = 50;
        default: stall_pct = 85;
      endcase
      case ($urandom_range(2))
        0:       gap_max = 0;
        1:       gap_max = 3;
        default: gap_max = 12;
      endcase

      n = $urandom_range(6, 40);
      for (k = 0; k < n; k++) begin
        case ($urandom_range(7))
          0:       x = 8'd0;
          1:       x = 8'd255;
          default: x = 8'($urandom_range(255));
        endcase
        send_sample(x, 1'b0, 64'sd0, 1'b0);
        rand_items++;
      end
    end

    // Drain and give stray results a chance to show up.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d samples in %0d completed blocks, %0d bin results, %0d register writes.",
             n_samples, n_blocks, n_results, n_cfg);
    $display("Mismatches and unexpected results: %0d", errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
design/gtb_pkg.sv
design/gtb_cfg_regs.sv
design/gtb_mac_unit.sv
design/goertzel_tone_bank_top.sv
verif/tb_goertzel_tone_bank_top.sv
